### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/h2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2d_pkg
// shared widths, register indexes and defaults of the 2d haar wavelet unit
// ----------------------------------------------------------------------------
package h2d_pkg;

    localparam int PIXEL_W        = 12;
    localparam int COEF_W         = 14;
    localparam int POS_W          = 12;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 4 * COEF_W + 2 * POS_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int SIZE_W         = 13;
    localparam int MAX_HEIGHT     = 4096;
    localparam int IMG_RESET      = 4096;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        SLOT_CORNER,
        SLOT_RIGHT,
        SLOT_BOTTOM,
        SLOT_LAST
    } slot_t;

endpackage

### src/haar_2d_wavelet_decompose_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haar_2d_wavelet_decompose_unit
// one-level 2d haar decomposition of a raster pixel stream
// ----------------------------------------------------------------------------
// pixels enter on s_axis in raster order, one item per cycle when tready is set.
// coefficient sets leave on the m_axis channel: ll, hl, lh, hh (times four),
// the subband row and column, tuser flags the last set caused by a pixel
// and tlast the last set of the frame.
// the cfg channel writes mode, image width and image height; the user must
// write them only while the unit is idle, which the unit does not enforce.
// any write of a known register restarts the frame. a set goes through the
// pixel stage, loaded when its pixel is accepted, and then the output register.
// throughput: one pixel per cycle while each pixel gives at most one set and
// the receiver does not stall; a pixel giving more sets holds off the next
// pixel until its last set is loaded (undecimated row ends and last row).
// the previous row sits in a ram with a registered read port; its address
// is fetched one pixel ahead, with a bypass for a one-pixel-wide image.
// reset clears counters, control registers and flags; payload registers and
// ram contents stay unknown until written, which always happens before a read.
// when the receiver stalls, the output register holds and the pixel stage
// stops accepting once its pending sets cannot drain.
// ----------------------------------------------------------------------------
module haar_2d_wavelet_decompose_unit import h2d_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pixel, zero pad
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // ll, hl, lh, hh, out_row, out_col
    output logic                   m_axis_tuser,  // last_of_item
    output logic                   m_axis_tlast,  // frame_end
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW          = $clog2(MAX_WIDTH);
    localparam int SW          = (PIXEL_BITS + 2 > COEF_W) ? PIXEL_BITS + 2 : COEF_W;
    localparam int EFF_W_RESET = (IMG_RESET < MAX_WIDTH) ? IMG_RESET : MAX_WIDTH;

    // configuration
    logic              mode_reg;
    logic [SIZE_W-1:0] wlast_reg;
    logic [SIZE_W-1:0] hlast_reg;
    logic              cfg_we;
    logic              mode_next;
    logic [SIZE_W-1:0] wlast_next;
    logic [SIZE_W-1:0] hlast_next;

    // raster position and neighbours
    logic [POS_W-1:0]      col_reg, col_next;
    logic [POS_W-1:0]      row_reg, row_next;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] above_left_reg;
    logic                  byp_reg;
    logic [PIXEL_BITS-1:0] byp_data_reg;
    logic [PIXEL_BITS-1:0] ram_q;
    logic [PIXEL_BITS-1:0] above;
    logic [PIXEL_BITS-1:0] x;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  in_acc;
    logic                  lastc;
    logic                  lastr;
    logic [3:0]            mask_new;

    // pixel stage
    logic [PIXEL_BITS-1:0] st_x_reg, st_above_reg, st_lft_reg, st_al_reg;
    logic [POS_W-1:0]      st_row_reg, st_col_reg;
    logic                  st_lastr_reg, st_lastc_reg, st_mode_reg;
    logic [3:0]            pend_reg, pend_next;

    // set selection
    slot_t                 sel;
    logic [3:0]            sel_bit;
    logic                  load_out;
    logic [3:0]            pend_left;
    logic [PIXEL_BITS-1:0] op_a, op_b, op_c, op_d;
    logic [POS_W-1:0]      op_row, op_col;
    logic [SW-1:0]         sa, sb, sc, sd;
    logic [SW-1:0]         ll_w, hl_w, lh_w, hh_w;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_user_reg;
    logic                   out_last_reg;

    // configuration decode
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_we     = 1'b0;
        mode_next  = mode_reg;
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:
                begin
                    cfg_we    = 1'b1;
                    mode_next = cfg_data[0];
                end
                REG_WIDTH:
                begin
                    cfg_we = 1'b1;
                    if (cfg_data == '0)
                        wlast_next = '0;
                    else if ({2'b00, cfg_data} > 15'(MAX_WIDTH))
                        wlast_next = SIZE_W'(MAX_WIDTH - 1);
                    else
                        wlast_next = cfg_data - 1'b1;
                end
                REG_HEIGHT:
                begin
                    cfg_we = 1'b1;
                    if (cfg_data == '0)
                        hlast_next = '0;
                    else if (cfg_data > SIZE_W'(MAX_HEIGHT))
                        hlast_next = SIZE_W'(MAX_HEIGHT - 1);
                    else
                        hlast_next = cfg_data - 1'b1;
                end
                default:
                begin
                    cfg_we = 1'b0;
                end
            endcase
        end
    end

    // input side
    assign x       = PIXEL_BITS'(s_axis_tdata[PIXEL_W-1:0]);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign lastc   = {1'b0, col_reg} >= wlast_reg;
    assign lastr   = {1'b0, row_reg} >= hlast_reg;
    assign above   = byp_reg ? byp_data_reg : ram_q;
    assign wr_addr = AW'(col_reg);
    assign rd_addr = AW'(col_next);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (lastc)
            begin
                col_next = '0;
                row_next = lastr ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        mask_new = '0;
        if (!mode_reg)
        begin
            mask_new[0] = (col_reg[0] || lastc) && (row_reg[0] || lastr);
        end
        else
        begin
            mask_new[0] = (row_reg != '0) && (col_reg != '0);
            mask_new[1] = (row_reg != '0) && lastc;
            mask_new[2] = lastr && (col_reg != '0);
            mask_new[3] = lastr && lastc;
        end
    end

    h2d_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (in_acc),
        .waddr (wr_addr),
        .wdata (x),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // set selection, lowest pending slot first
    always_comb
    begin
        if (pend_reg[0])
            sel = SLOT_CORNER;
        else if (pend_reg[1])
            sel = SLOT_RIGHT;
        else if (pend_reg[2])
            sel = SLOT_BOTTOM;
        else
            sel = SLOT_LAST;
    end

    assign sel_bit   = 4'b0001 << sel;
    assign pend_left = pend_reg & ~sel_bit;
    assign load_out  = (pend_reg != '0) && (!out_valid_reg || m_axis_tready);
    assign pend_next = load_out ? pend_left : pend_reg;
    assign s_axis_tready = (pend_next == '0);

    always_comb
    begin
        op_a   = st_x_reg;
        op_b   = st_x_reg;
        op_c   = st_x_reg;
        op_d   = st_x_reg;
        op_row = st_row_reg;
        op_col = st_col_reg;
        if (!st_mode_reg)
        begin
            op_c   = st_col_reg[0] ? st_lft_reg : st_x_reg;
            op_d   = st_x_reg;
            op_a   = st_row_reg[0] ? (st_col_reg[0] ? st_al_reg : st_above_reg) : op_c;
            op_b   = st_row_reg[0] ? st_above_reg : st_x_reg;
            op_row = st_row_reg >> 1;
            op_col = st_col_reg >> 1;
        end
        else
        begin
            case (sel)
                SLOT_CORNER:
                begin
                    op_a   = st_al_reg;
                    op_b   = st_above_reg;
                    op_c   = st_lft_reg;
                    op_row = st_row_reg - 1'b1;
                    op_col = st_col_reg - 1'b1;
                end
                SLOT_RIGHT:
                begin
                    op_a   = st_above_reg;
                    op_b   = st_above_reg;
                    op_row = st_row_reg - 1'b1;
                end
                SLOT_BOTTOM:
                begin
                    op_a   = st_lft_reg;
                    op_c   = st_lft_reg;
                    op_col = st_col_reg - 1'b1;
                end
                default:
                begin
                    op_a = st_x_reg;
                end
            endcase
        end
    end

    assign sa   = SW'(op_a);
    assign sb   = SW'(op_b);
    assign sc   = SW'(op_c);
    assign sd   = SW'(op_d);
    assign ll_w = sa + sb + sc + sd;
    assign hl_w = sa - sb + sc - sd;
    assign lh_w = sa + sb - sc - sd;
    assign hh_w = sa - sb - sc + sd;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            wlast_reg      <= SIZE_W'(EFF_W_RESET - 1);
            hlast_reg      <= SIZE_W'(MAX_HEIGHT - 1);
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            above_left_reg <= '0;
            byp_reg        <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            wlast_reg     <= wlast_next;
            hlast_reg     <= hlast_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            byp_reg       <= in_acc && (wr_addr == rd_addr);
            pend_reg      <= in_acc ? mask_new : pend_next;
            out_valid_reg <= out_valid_next;
            if (in_acc)
            begin
                left_reg       <= x;
                above_left_reg <= above;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byp_data_reg <= x;
            st_x_reg     <= x;
            st_above_reg <= above;
            st_lft_reg   <= left_reg;
            st_al_reg    <= above_left_reg;
            st_row_reg   <= row_reg;
            st_col_reg   <= col_reg;
            st_lastr_reg <= lastr;
            st_lastc_reg <= lastc;
            st_mode_reg  <= mode_reg;
        end
        if (load_out)
        begin
            out_data_reg <= {op_col, op_row, hh_w[COEF_W-1:0], lh_w[COEF_W-1:0],
                             hl_w[COEF_W-1:0], ll_w[COEF_W-1:0]};
            out_user_reg <= (pend_left == '0);
            out_last_reg <= (pend_left == '0) && st_lastr_reg && st_lastc_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### src/h2d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2d_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module h2d_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/h2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2d_checker
// port-level checks of the 2d haar wavelet unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h2d_checker import h2d_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic [1:0] low_sum;

    // ll + hl + lh + hh is four times the top left pixel
    assign low_sum = 2'(m_axis_tdata[1:0] + m_axis_tdata[COEF_W+1:COEF_W]
                      + m_axis_tdata[2*COEF_W+1:2*COEF_W]
                      + m_axis_tdata[3*COEF_W+1:3*COEF_W]);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMPLIES(a_frame_end_last, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    `ASSERT_IMPLIES(a_coef_parity, clk, rst_n, m_axis_tvalid, (m_axis_tdata[0] == m_axis_tdata[COEF_W]) && (m_axis_tdata[0] == m_axis_tdata[2*COEF_W]) && (m_axis_tdata[0] == m_axis_tdata[3*COEF_W]))
    `ASSERT_IMPLIES(a_coef_sum, clk, rst_n, m_axis_tvalid, low_sum == 2'b00)

endmodule

bind haar_2d_wavelet_decompose_unit h2d_checker u_h2d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
